FILE: rtl/cdwe_pkg.sv
// Package for the residue-sum watermark embedder: field widths, register
// indexes, residue helpers and the channel payload types.
// No dependencies; the front, back, top and bench files import it.
`default_nettype none

package cdwe_pkg;

	// Field and register widths
	localparam int DC_W   = 14;
	localparam int MV_W   = 15;
	localparam int THR_W  = 8;
	localparam int EOFS_W = 8;
	localparam int UB_W   = 13;
	localparam int CFG_W  = 13;
	localparam int IDX_W  = 2;

	// Search and residue constants
	localparam int SEARCH_STEP  = 8;
	localparam int SEARCH_LIMIT = 256;
	localparam int MODULUS_A    = 38;
	localparam int MODULUS_B    = 107;

	// Register indexes on the write port
	localparam logic [IDX_W-1:0] REG_SUM_THRESHOLD = 2'd0;
	localparam logic [IDX_W-1:0] REG_EMBED_OFFSET  = 2'd1;
	localparam logic [IDX_W-1:0] REG_UPPER_BOUND   = 2'd2;

	// Register reset values
	localparam logic [THR_W-1:0]  THR_RESET  = 8'd70;
	localparam logic [EOFS_W-1:0] EOFS_RESET = 8'd45;
	localparam logic [UB_W-1:0]   UB_RESET   = 13'd4080;

	// Input queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Residue arithmetic
	localparam int MOD_MAX  = (MODULUS_A > MODULUS_B) ? MODULUS_A : MODULUS_B;
	localparam int RES_W    = $clog2(MOD_MAX);
	localparam int SUM_W    = (RES_W + 2 > THR_W + 1) ? RES_W + 2 : THR_W + 1;
	localparam int MOD_PROD = MODULUS_A * MODULUS_B;
	// Multiple of both moduli that lifts any coefficient to a nonnegative value
	localparam int LIFT     = MOD_PROD * ((2**(DC_W-1) + MOD_PROD - 1) / MOD_PROD);
	localparam int U_W      = $clog2(2**(DC_W-1) + LIFT);
	localparam int STEP_A   = SEARCH_STEP % MODULUS_A;
	localparam int STEP_B   = SEARCH_STEP % MODULUS_B;

	localparam logic [RES_W:0]   MOD_A_V  = (RES_W+1)'(MODULUS_A);
	localparam logic [RES_W:0]   MOD_B_V  = (RES_W+1)'(MODULUS_B);
	localparam logic [RES_W-1:0] STEP_A_V = RES_W'(STEP_A);
	localparam logic [RES_W-1:0] STEP_B_V = RES_W'(STEP_B);

	// Reciprocal remainder: (u * RCP) >> SH is the exact quotient for any u below 2**U_W
	localparam int SH_A   = U_W + $clog2(MODULUS_A);
	localparam int SH_B   = U_W + $clog2(MODULUS_B);
	localparam int RCP_W  = U_W + 1;
	localparam int PROD_W = U_W + RCP_W;
	localparam int RCP_A  = (2**SH_A + MODULUS_A - 1) / MODULUS_A;
	localparam int RCP_B  = (2**SH_B + MODULUS_B - 1) / MODULUS_B;

	localparam logic [RCP_W-1:0] RCP_A_V = RCP_W'(RCP_A);
	localparam logic [RCP_W-1:0] RCP_B_V = RCP_W'(RCP_B);
	localparam logic [U_W-1:0]   MOD_A_U = U_W'(MODULUS_A);
	localparam logic [U_W-1:0]   MOD_B_U = U_W'(MODULUS_B);

	// Candidate value and offset counter widths
	localparam int CAND_W = $clog2(2**(DC_W-1) + SEARCH_LIMIT) + 1;
	localparam int J_W    = $clog2(SEARCH_LIMIT + SEARCH_STEP + 1);

	typedef struct packed {
		logic signed [DC_W-1:0] dc_value;
		logic                   watermark_bit;
	} coef_t;

	typedef struct packed {
		logic signed [MV_W-1:0] marked_value;
		logic                   not_found;
	} mark_t;

	typedef struct packed {
		logic [THR_W-1:0]  sum_threshold;
		logic [EOFS_W-1:0] embed_offset;
		logic [UB_W-1:0]   upper_bound;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_SEARCH,
		ST_OUT
	} state_t;

	// Floored residue plus a step residue
	function automatic logic [RES_W-1:0] mod_add(input logic [RES_W-1:0] r,
	                                             input logic [RES_W-1:0] s,
	                                             input logic [RES_W:0] m);
		logic [RES_W:0] t;
		t = {1'b0, r} + {1'b0, s};
		if (t >= m)
			t = t - m;
		return t[RES_W-1:0];
	endfunction

	// Floored residue minus a step residue
	function automatic logic [RES_W-1:0] mod_sub(input logic [RES_W-1:0] r,
	                                             input logic [RES_W-1:0] s,
	                                             input logic [RES_W:0] m);
		logic [RES_W:0] t;
		if (r >= s)
			t = {1'b0, r} - {1'b0, s};
		else
			t = {1'b0, r} + m - {1'b0, s};
		return t[RES_W-1:0];
	endfunction

	// Turn a floored residue into the truncated one for a value of given sign
	function automatic logic signed [SUM_W-1:0] trunc_res(input logic [RES_W-1:0] f,
	                                                      input logic neg,
	                                                      input logic [RES_W:0] m);
		logic signed [SUM_W-1:0] fe;
		logic signed [SUM_W-1:0] me;
		fe = $signed({{(SUM_W-RES_W){1'b0}}, f});
		me = $signed({{(SUM_W-RES_W-1){1'b0}}, m});
		if (neg && (f != '0))
			return fe - me;
		return fe;
	endfunction

	// Residue sum condition for the bit to embed
	function automatic logic meets(input logic signed [SUM_W-1:0] s,
	                               input logic [THR_W-1:0] thr,
	                               input logic b);
		logic signed [SUM_W-1:0] te;
		te = $signed({{(SUM_W-THR_W){1'b0}}, thr});
		if (b)
			return s >= te;
		return s < te;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/cdwe_stream_if.sv
// Valid/ready channel with a typed payload, source and sink views.
// Payload types come from cdwe_pkg.
`default_nettype none

interface cdwe_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/cdwe_front.sv
// Front end: accepts coefficient items into a short queue for the search engine.
// Depends on cdwe_pkg and cdwe_stream_if.
`default_nettype none

module cdwe_front (
	input  wire logic clk,
	input  wire logic arst_n,
	cdwe_stream_if.sink   coef,
	cdwe_stream_if.source job
);
	import cdwe_pkg::*;

	coef_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	// Handshake on both sides of the queue
	assign coef.ready  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign job.valid   = (cnt_q != '0);
	assign job.payload = entry_q[rd_ptr_q];
	assign push        = coef.valid && coef.ready;
	assign pop         = job.valid && job.ready;

	// Store an accepted item
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= coef.payload;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/cdwe_back.sv
// Back end: residues by a reciprocal-multiply remainder unit, then an
// offset search that steps both residues incrementally, one offset per cycle.
// Depends on cdwe_pkg and cdwe_stream_if.
`default_nettype none

module cdwe_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cdwe_pkg::cfg_t cfg,
	cdwe_stream_if.sink       job,
	cdwe_stream_if.source     mark
);
	import cdwe_pkg::*;

	state_t                   state_q;
	state_t                   state_d;

	logic signed [DC_W-1:0]   z_q;
	logic                     bit_q;
	logic [U_W-1:0]           u_q;
	logic                     ph_q;
	logic [U_W-1:0]           qa_q;
	logic [U_W-1:0]           qb_q;
	logic [RES_W-1:0]         fu_a_q;
	logic [RES_W-1:0]         fu_b_q;
	logic [RES_W-1:0]         fd_a_q;
	logic [RES_W-1:0]         fd_b_q;
	logic [J_W-1:0]           j_q;
	logic signed [MV_W-1:0]   res_q;
	logic                     nf_q;
	mark_t                    out_q;
	logic                     out_valid_q;

	logic                     take;
	logic                     mod_last;
	logic [PROD_W-1:0]        prod_a;
	logic [PROD_W-1:0]        prod_b;
	logic [U_W-1:0]           rem_a;
	logic [U_W-1:0]           rem_b;
	logic [RES_W-1:0]         ra_n;
	logic [RES_W-1:0]         rb_n;
	logic signed [CAND_W-1:0] z_ext;
	logic signed [CAND_W-1:0] j_ext;
	logic signed [CAND_W-1:0] ub_ext;
	logic signed [CAND_W-1:0] cand_up;
	logic signed [CAND_W-1:0] cand_dn;
	logic signed [SUM_W-1:0]  s_up;
	logic signed [SUM_W-1:0]  s_dn;
	logic                     first;
	logic                     up_hit;
	logic                     dn_hit;
	logic [J_W-1:0]           j_nx;
	logic                     srch_last;
	logic                     srch_done;
	logic                     found;
	logic signed [CAND_W-1:0] chosen;
	logic [CAND_W:0]          result;
	logic                     out_load;

	// Quotients of the lifted coefficient by reciprocal multiply, then remainders
	assign prod_a   = PROD_W'(u_q) * PROD_W'(RCP_A_V);
	assign prod_b   = PROD_W'(u_q) * PROD_W'(RCP_B_V);
	assign rem_a    = u_q - qa_q * MOD_A_U;
	assign rem_b    = u_q - qb_q * MOD_B_U;
	assign ra_n     = rem_a[RES_W-1:0];
	assign rb_n     = rem_b[RES_W-1:0];
	assign mod_last = ph_q;

	// Candidate pair for the current offset
	assign z_ext   = CAND_W'(z_q);
	assign j_ext   = $signed({{(CAND_W-J_W){1'b0}}, j_q});
	assign ub_ext  = $signed({{(CAND_W-UB_W){1'b0}}, cfg.upper_bound});
	assign cand_up = z_ext + j_ext;
	assign cand_dn = z_ext - j_ext;
	assign first   = (j_q == '0);
	assign s_up    = trunc_res(fu_a_q, cand_up[CAND_W-1], MOD_A_V)
	               + trunc_res(fu_b_q, cand_up[CAND_W-1], MOD_B_V);
	assign s_dn    = trunc_res(fd_a_q, cand_dn[CAND_W-1], MOD_A_V)
	               + trunc_res(fd_b_q, cand_dn[CAND_W-1], MOD_B_V);
	assign up_hit  = (first || (cand_up < ub_ext)) && meets(s_up, cfg.sum_threshold, bit_q);
	assign dn_hit  = !first && (cand_dn > 0) && meets(s_dn, cfg.sum_threshold, bit_q);
	assign j_nx    = j_q + J_W'(SEARCH_STEP);
	assign srch_last = (j_nx >= J_W'(SEARCH_LIMIT));
	assign found     = up_hit || dn_hit;
	assign srch_done = found || srch_last;

	// Pick the result, add the embed offset for a found bit 1
	always_comb begin
		if (up_hit)
			chosen = cand_up;
		else if (dn_hit)
			chosen = cand_dn;
		else
			chosen = z_ext;
		if (found && bit_q)
			result = {chosen[CAND_W-1], chosen}
			       + {{(CAND_W+1-EOFS_W){1'b0}}, cfg.embed_offset};
		else
			result = {chosen[CAND_W-1], chosen};
	end

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || mark.ready);
	assign take     = job.valid && job.ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and job handshake
	always_comb begin
		state_d   = state_q;
		job.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				job.ready = 1'b1;
				if (job.valid)
					state_d = ST_MOD;
			end
			ST_MOD: begin
				if (mod_last)
					state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (srch_done)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Working registers of the residue unit and the search
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					z_q   <= job.payload.dc_value;
					bit_q <= job.payload.watermark_bit;
					u_q   <= U_W'(job.payload.dc_value) + U_W'(LIFT);
					ph_q  <= 1'b0;
				end
			end
			ST_MOD: begin
				if (!ph_q) begin
					qa_q <= U_W'(prod_a >> SH_A);
					qb_q <= U_W'(prod_b >> SH_B);
					ph_q <= 1'b1;
				end else begin
					fu_a_q <= ra_n;
					fu_b_q <= rb_n;
					fd_a_q <= ra_n;
					fd_b_q <= rb_n;
					j_q    <= '0;
				end
			end
			ST_SEARCH: begin
				if (srch_done) begin
					res_q <= result[MV_W-1:0];
					nf_q  <= !found;
				end else begin
					fu_a_q <= mod_add(fu_a_q, STEP_A_V, MOD_A_V);
					fu_b_q <= mod_add(fu_b_q, STEP_B_V, MOD_B_V);
					fd_a_q <= mod_sub(fd_a_q, STEP_A_V, MOD_A_V);
					fd_b_q <= mod_sub(fd_b_q, STEP_B_V, MOD_B_V);
					j_q    <= j_nx;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.marked_value <= res_q;
			out_q.not_found    <= nf_q;
		end
	end

	// Output register valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (mark.ready)
			out_valid_q <= 1'b0;
	end

	assign mark.valid   = out_valid_q;
	assign mark.payload = out_q;

endmodule

`default_nettype wire

FILE: rtl/crt_dc_watermark_embed.sv
// Channel  Dir  Payload                          Handshake
// coef     in   dc_value[13:0] s, watermark_bit  valid/ready
// mark     out  marked_value[14:0] s, not_found  valid/ready
// wr_*     in   wr_index[1:0], wr_data[12:0]     wr_en, no back-pressure
//
// The search engine takes one item at a time: it loads it, finds the residues in the
// reciprocal-multiply remainder unit, tries the coefficient itself, then offset pairs
// (1 to 32 candidates in all), and moves the result to the output register.
// A two-entry input queue and the output register let both sides stall freely.
// Reset empties the queue and engine, drops the output valid, presets the registers.
// Top level: register file and the front/back split.
// Depends on cdwe_pkg, cdwe_stream_if, cdwe_front and cdwe_back.
`default_nettype none

module crt_dc_watermark_embed (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      wr_en,
	input  wire logic [cdwe_pkg::IDX_W-1:0] wr_index,
	input  wire logic [cdwe_pkg::CFG_W-1:0] wr_data,
	cdwe_stream_if.sink                    coef,
	cdwe_stream_if.source                  mark
);
	import cdwe_pkg::*;

	cfg_t cfg_q;

	cdwe_stream_if #(.payload_t(coef_t)) job ();

	// Register writes; an index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sum_threshold <= THR_RESET;
			cfg_q.embed_offset  <= EOFS_RESET;
			cfg_q.upper_bound   <= UB_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SUM_THRESHOLD: cfg_q.sum_threshold <= wr_data[THR_W-1:0];
				REG_EMBED_OFFSET:  cfg_q.embed_offset  <= wr_data[EOFS_W-1:0];
				REG_UPPER_BOUND:   cfg_q.upper_bound   <= wr_data[UB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	cdwe_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.coef   (coef),
		.job    (job.source)
	);

	cdwe_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.job    (job.sink),
		.mark   (mark)
	);

endmodule

`default_nettype wire

FILE: dv/crt_dc_watermark_embed_test.sv
// Self-checking bench for crt_dc_watermark_embed: random and directed DC items
// over several register settings, results checked against an in-bench predictor.
// Depends on cdwe_pkg, cdwe_stream_if and the crt_dc_watermark_embed RTL.
`default_nettype none

module crt_dc_watermark_embed_test;
	import cdwe_pkg::*;

	// Write to the unused register slot; the block must ignore it
	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
	// Cycles to let pass after the last result before a write or the end
	localparam int SETTLE_CYCLES = 60;
	// Receiver hold-off used to back the block up
	localparam int HOLD_CYCLES   = 300;
	localparam int HOLD_AFTER    = 400;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [CFG_W-1:0] wr_data;

	cdwe_stream_if #(.payload_t(coef_t)) coef_ch ();
	cdwe_stream_if #(.payload_t(mark_t)) mark_ch ();

	crt_dc_watermark_embed dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.coef     (coef_ch),
		.mark     (mark_ch)
	);

	// Predictor copy of the registers
	logic [THR_W-1:0]  thr_reg;
	logic [EOFS_W-1:0] eofs_reg;
	logic [UB_W-1:0]   ub_reg;

	coef_t coef_pending[$];
	mark_t mark_expected[$];

	int unsigned items_accepted;
	int unsigned fail_count;
	bit send_idling;
	bit recv_idling;
	bit recv_block;

	// Truncated residues of both moduli, summed
	function automatic int residue_pair_sum(int v);
		return (v % MODULUS_A) + (v % MODULUS_B);
	endfunction

	function automatic bit bit_fits(int v, logic b);
		int s;
		s = residue_pair_sum(v);
		if (b)
			return s >= int'(thr_reg);
		return s < int'(thr_reg);
	endfunction

	// Search for the nearest coefficient that carries the bit
	function automatic mark_t predict_mark(coef_t c);
		int z;
		int cand;
		int j;
		int outv;
		bit hit;
		mark_t m;
		z = int'(c.dc_value);
		cand = z;
		hit = bit_fits(z, c.watermark_bit);
		for (j = SEARCH_STEP; j < SEARCH_LIMIT && !hit; j += SEARCH_STEP) begin
			if (z + j < int'(ub_reg) && bit_fits(z + j, c.watermark_bit)) begin
				cand = z + j;
				hit = 1'b1;
			end else if (z - j > 0 && bit_fits(z - j, c.watermark_bit)) begin
				cand = z - j;
				hit = 1'b1;
			end
		end
		if (!hit)
			outv = z;
		else if (c.watermark_bit)
			outv = cand + int'(eofs_reg);
		else
			outv = cand;
		m.marked_value = outv[MV_W-1:0];
		m.not_found = !hit;
		return m;
	endfunction

	task automatic flag_failure(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Drive coefficient items from the pending queue, with idle bursts
	always @(posedge clk or negedge arst_n) begin : drive_coef
		int unsigned gap_left;
		logic nxt_valid;
		coef_t nxt_item;
		if (!arst_n) begin
			coef_ch.valid <= 1'b0;
			coef_ch.payload <= '0;
			gap_left = 0;
		end else begin
			if (coef_ch.valid && coef_ch.ready) begin
				mark_expected = {mark_expected, predict_mark(coef_ch.payload)};
				items_accepted++;
			end
			// hold an item that is still waiting
			if (!(coef_ch.valid && !coef_ch.ready)) begin
				nxt_valid = 1'b0;
				nxt_item = coef_ch.payload;
				if (gap_left > 0) begin
					gap_left--;
				end else if (send_idling && $urandom_range(0, 5) == 0) begin
					gap_left = $urandom_range(1, 13) - 1;
				end else if (coef_pending.size() > 0) begin
					nxt_valid = 1'b1;
					nxt_item = coef_pending.pop_front();
				end
				coef_ch.valid <= nxt_valid;
				coef_ch.payload <= nxt_item;
			end
		end
	end

	// Check each result against the oldest prediction; stall at random
	always @(posedge clk or negedge arst_n) begin : check_mark
		int unsigned stall_left;
		logic nxt_ready;
		mark_t want;
		if (!arst_n) begin
			mark_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (mark_ch.valid && mark_ch.ready) begin
				if (mark_expected.size() == 0) begin
					flag_failure($sformatf("unexpected result: marked_value=%0d not_found=%0b",
						mark_ch.payload.marked_value, mark_ch.payload.not_found));
				end else begin
					want = mark_expected.pop_front();
					if (mark_ch.payload.marked_value !== want.marked_value ||
					    mark_ch.payload.not_found !== want.not_found)
						flag_failure($sformatf(
							"mismatch: marked_value exp %0d got %0d, not_found exp %0b got %0b",
							want.marked_value, mark_ch.payload.marked_value,
							want.not_found, mark_ch.payload.not_found));
				end
			end
			nxt_ready = 1'b1;
			if (recv_block) begin
				nxt_ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				nxt_ready = 1'b0;
			end else if (recv_idling && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 13) - 1;
				nxt_ready = 1'b0;
			end
			mark_ch.ready <= nxt_ready;
		end
	end

	// Hold off the receiver once while items keep coming
	initial begin
		recv_block = 1'b0;
		wait (items_accepted >= HOLD_AFTER);
		@(posedge clk);
		recv_block <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		recv_block <= 1'b0;
	end

	// Overall time limit
	initial begin
		#1500000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// Write all three registers; upper data bits of the narrow ones are noise
	task automatic set_config(logic [THR_W-1:0] thr, logic [EOFS_W-1:0] eofs,
	                          logic [UB_W-1:0] ub);
		write_reg(REG_SUM_THRESHOLD, {5'($urandom), thr});
		write_reg(REG_EMBED_OFFSET, {5'($urandom), eofs});
		write_reg(REG_UPPER_BOUND, ub);
		thr_reg = thr;
		eofs_reg = eofs;
		ub_reg = ub;
	endtask

	task automatic add_coef(int v, logic b);
		coef_t c;
		c.dc_value = v[DC_W-1:0];
		c.watermark_bit = b;
		coef_pending = {coef_pending, c};
	endtask

	// Coefficients spread over the full range, near zero, near the bound and over 0 to 4200
	function automatic int pick_dc();
		case ($urandom_range(0, 3))
			0: return int'($urandom_range(0, 16383)) - 8192;
			1: return int'($urandom_range(0, 600)) - 300;
			2: return int'(ub_reg) - int'($urandom_range(0, 270));
			default: return int'($urandom_range(0, 4200));
		endcase
	endfunction

	// Wait until every prediction has been met, then let the engine settle
	task automatic drain();
		while (!(coef_pending.size() == 0 && !coef_ch.valid && mark_expected.size() == 0))
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(int count, bit idle_on);
		int i;
		@(posedge clk);
		send_idling <= idle_on;
		recv_idling <= idle_on;
		for (i = 0; i < count; i++)
			add_coef(pick_dc(), 1'($urandom_range(0, 1)));
		drain();
	endtask

	// Reset, directed items, then random phases over several settings
	initial begin
		int p;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		send_idling = 1'b0;
		recv_idling = 1'b0;
		items_accepted = 0;
		fail_count = 0;
		thr_reg = THR_RESET;
		eofs_reg = EOFS_RESET;
		ub_reg = UB_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// field extremes, the largest residue sum, negative sums, edges of the bound
		add_coef(-8192, 1'b0);
		add_coef(-8192, 1'b1);
		add_coef(8191, 1'b0);
		add_coef(8191, 1'b1);
		add_coef(0, 1'b0);
		add_coef(0, 1'b1);
		add_coef(-1, 1'b0);
		add_coef(-1, 1'b1);
		add_coef(1, 1'b1);
		add_coef(4065, 1'b0);
		add_coef(4065, 1'b1);
		add_coef(-4065, 1'b1);
		add_coef(4079, 1'b1);
		add_coef(4080, 1'b1);
		add_coef(4072, 1'b0);
		add_coef(7, 1'b1);
		add_coef(8, 1'b0);
		add_coef(37, 1'b0);
		add_coef(-200, 1'b1);
		add_coef(-300, 1'b1);
		add_coef(100, 1'b0);
		add_coef(100, 1'b1);
		drain();

		run_random(150, 1'b1);

		// low extremes: bit 0 can never hold for a nonnegative sum
		set_config('0, '0, '0);
		run_random(130, 1'b1);

		// high extremes: bit 1 can never hold
		set_config('1, '1, '1);
		run_random(130, 1'b0);

		// ignored slot, then a threshold at the largest possible sum
		write_reg(REG_SPARE, 13'($urandom));
		set_config(8'd143, 8'd1, UB_RESET);
		run_random(130, 1'b1);

		for (p = 0; p < 6; p++) begin
			set_config(8'($urandom_range(0, 150)), 8'($urandom), 13'($urandom));
			run_random(130, p[0]);
		end

		// closing phase without idling
		set_config(8'($urandom_range(30, 110)), 8'($urandom), 13'($urandom_range(0, 8191)));
		run_random(130, 1'b0);

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
rtl/cdwe_pkg.sv
rtl/cdwe_stream_if.sv
rtl/cdwe_front.sv
rtl/cdwe_back.sv
rtl/crt_dc_watermark_embed.sv
dv/crt_dc_watermark_embed_test.sv
